// ----- design/sfsd_pkg.sv -----
// Shared types, constants and helpers for the SBUS frame sync and channel decoder.
package sfsd_pkg;

    localparam int FRAME_LEN  = 25;
    localparam int WIN_LEN    = FRAME_LEN - 1;
    localparam int NUM_SLOTS  = 16;
    localparam int SLOT_W     = $clog2(NUM_SLOTS);
    localparam int CNT_W      = $clog2(FRAME_LEN);
    localparam int RAW_W      = 11;
    localparam int PULSE_W    = 12;
    localparam int PAYLOAD_B  = 22;
    localparam int FRAME_W    = PAYLOAD_B * 8;

    localparam logic [7:0] SBUS_HEADER = 8'h0F;
    localparam logic [7:0] FOOTER_A    = 8'h04;
    localparam logic [7:0] FOOTER_B    = 8'h14;
    localparam logic [7:0] FOOTER_C    = 8'h24;
    localparam logic [7:0] FOOTER_D    = 8'h34;

    // Pulse width = (5*raw + 7040) >> 3
    localparam logic [14:0] PULSE_BIAS = 15'd7040;

    localparam logic [CNT_W-1:0] CHECK_COUNT = CNT_W'(WIN_LEN);
    localparam logic [SLOT_W-1:0] LAST_SLOT  = SLOT_W'(NUM_SLOTS - 1);

    typedef logic [FRAME_W-1:0] t_frame;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_status;

    // Bit offset of each slot inside the payload (frame bytes 1..22).
    typedef logic [7:0] t_slot_ofs [NUM_SLOTS];
    localparam t_slot_ofs SLOT_OFS = '{
        8'd0,   8'd44,  8'd22,  8'd11,  8'd33,  8'd55,  8'd66,  8'd77,
        8'd88,  8'd99,  8'd110, 8'd121, 8'd132, 8'd143, 8'd154, 8'd165
    };

    function automatic logic footer_ok(input logic [7:0] v);
        return (v == FOOTER_A) || (v == FOOTER_B) || (v == FOOTER_C) || (v == FOOTER_D);
    endfunction

    function automatic logic [PULSE_W-1:0] raw_to_pulse(input logic [RAW_W-1:0] raw);
        logic [14:0] sum;
        sum = {2'b00, raw, 2'b00} + {4'b0000, raw} + PULSE_BIAS;
        return sum[14:3];
    endfunction

endpackage

// ----- design/sfsd_front.sv -----
// Front end: byte window, pending count and frame header/footer check.
module sfsd_front (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_rx_acc,
    input  logic [7:0]          i_rx_byte,
    output logic                o_push,
    output sfsd_pkg::t_frame    o_frame
);
    import sfsd_pkg::*;

    // r_win[0] is the oldest pending byte after the next shift
    logic [7:0]       r_win [WIN_LEN];
    logic [CNT_W-1:0] r_cnt;
    logic [CNT_W-1:0] n_cnt;
    logic             hit;

    assign hit    = i_rx_acc && (r_cnt == CHECK_COUNT) && (r_win[0] == SBUS_HEADER)
                 && footer_ok(i_rx_byte);
    assign o_push = hit;

    always_comb begin
        for (int j = 0; j < PAYLOAD_B; j++) begin
            o_frame[j*8 +: 8] = r_win[j+1];
        end
    end

    always_comb begin
        n_cnt = r_cnt;
        if (i_rx_acc) begin
            if (hit) begin
                n_cnt = '0;
            end else if (r_cnt != CHECK_COUNT) begin
                n_cnt = r_cnt + CNT_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
            for (int i = 0; i < WIN_LEN; i++) begin
                r_win[i] <= '0;
            end
        end else begin
            r_cnt <= n_cnt;
            if (i_rx_acc) begin
                for (int i = 0; i < WIN_LEN - 1; i++) begin
                    r_win[i] <= r_win[i+1];
                end
                r_win[WIN_LEN-1] <= i_rx_byte;
            end
        end
    end

endmodule

// ----- design/sfsd_queue.sv -----
// Two-entry frame queue between the front end and the channel unpacker.
module sfsd_queue (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_push,
    input  sfsd_pkg::t_frame     i_frame,
    input  logic                 i_pop,
    output sfsd_pkg::t_frame     o_frame,
    output sfsd_pkg::t_q_status  o_status
);
    import sfsd_pkg::*;

    t_frame     r_mem [2];
    logic       r_wp;
    logic       r_rp;
    logic [1:0] r_cnt;

    assign o_frame        = r_mem[r_rp];
    assign o_status.full  = (r_cnt == 2'd2);
    assign o_status.empty = (r_cnt == 2'd0);

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_frame;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (i_push) begin
                r_wp <= ~r_wp;
            end
            if (i_pop) begin
                r_rp <= ~r_rp;
            end
            case ({i_push, i_pop})
                2'b10:   r_cnt <= r_cnt + 2'd1;
                2'b01:   r_cnt <= r_cnt - 2'd1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

endmodule

// ----- design/sfsd_back.sv -----
// Back end: unpacks one channel slot per cycle into the output register while not stalled.
module sfsd_back (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  sfsd_pkg::t_frame            i_frame,
    input  sfsd_pkg::t_q_status         i_status,
    output logic                        o_pop,
    input  logic                        i_stall,
    output logic                        o_valid,
    output logic [sfsd_pkg::SLOT_W-1:0] o_channel_index,
    output logic [sfsd_pkg::RAW_W-1:0]  o_raw_value,
    output logic [sfsd_pkg::PULSE_W-1:0] o_pulse_us,
    output logic                        o_last_channel
);
    import sfsd_pkg::*;

    logic [SLOT_W-1:0]  r_slot;
    logic               r_valid;
    logic [SLOT_W-1:0]  r_idx;
    logic [RAW_W-1:0]   r_raw;
    logic [PULSE_W-1:0] r_pulse;
    logic               r_last;
    logic [RAW_W-1:0]   cand [NUM_SLOTS];
    logic [RAW_W-1:0]   raw;
    logic               adv;
    logic               load;

    always_comb begin
        for (int i = 0; i < NUM_SLOTS; i++) begin
            cand[i] = i_frame[SLOT_OFS[i] +: RAW_W];
        end
    end

    assign raw   = cand[r_slot];
    assign adv   = !r_valid || !i_stall;
    assign load  = adv && !i_status.empty;
    assign o_pop = load && (r_slot == LAST_SLOT);

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_idx   <= r_slot;
            r_raw   <= raw;
            r_pulse <= raw_to_pulse(raw);
            r_last  <= (r_slot == LAST_SLOT);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_slot  <= '0;
        end else begin
            if (adv) begin
                r_valid <= !i_status.empty;
            end
            if (load) begin
                r_slot <= r_slot + SLOT_W'(1);
            end
        end
    end

    assign o_valid         = r_valid;
    assign o_channel_index = r_idx;
    assign o_raw_value     = r_raw;
    assign o_pulse_us      = r_pulse;
    assign o_last_channel  = r_last;

`ifndef ASSERT_OFF
    a_pop_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_pop |-> !i_status.empty)
        else $error("frame popped from empty queue");

    a_frame_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_slot != '0) |-> !i_status.empty)
        else $error("frame left queue while slots remain");

    a_pulse_match: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid |-> (r_pulse == raw_to_pulse(r_raw)))
        else $error("pulse width does not match raw value");

    a_last_index: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (load && (r_slot == LAST_SLOT)) |=> (r_last && (r_slot == '0)))
        else $error("slot counter did not wrap after last channel");
`endif

endmodule

// ----- design/sbus_frame_sync_channel_decode_top.sv -----
// Top level of the SBUS frame synchronizer and 16-channel decoder.
// Flow: a byte that completes a valid frame is pushed into the two-entry frame
//   queue; the unpacker then registers its 16 channel results on o_ch_valid.
// Throughput: one received byte per cycle while the queue is not full; one result
//   per cycle unless stalled, from the single-slot unpacker reading the queue head.
// Reset: synchronous, active low; clears the byte window to zero, the pending
//   count, the frame queue and the output valid flag.
module sbus_frame_sync_channel_decode_top (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // received byte channel
    input  logic                          i_rx_valid,
    output logic                          o_rx_stall,
    input  logic [7:0]                    i_rx_byte,
    // channel result channel
    output logic                          o_ch_valid,
    input  logic                          i_ch_stall,
    output logic [sfsd_pkg::SLOT_W-1:0]   o_channel_index,
    output logic [sfsd_pkg::RAW_W-1:0]    o_raw_value,
    output logic [sfsd_pkg::PULSE_W-1:0]  o_pulse_us,
    output logic                          o_last_channel
);
    import sfsd_pkg::*;

    logic      rx_acc;
    logic      push;
    logic      pop;
    t_frame    front_frame;
    t_frame    head_frame;
    t_q_status q_status;

    // Hold off bytes only while both queue slots hold frames; a frame needs
    // 25 bytes to assemble, so this only happens under long output stalls.
    assign o_rx_stall = q_status.full;
    assign rx_acc     = i_rx_valid && !o_rx_stall;

    // Shift in each byte, check header and footer, push matching frames
    sfsd_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_rx_acc  (rx_acc),
        .i_rx_byte (i_rx_byte),
        .o_push    (push),
        .o_frame   (front_frame)
    );

    // Decouple frame capture from channel emission
    sfsd_queue u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .i_frame  (front_frame),
        .i_pop    (pop),
        .o_frame  (head_frame),
        .o_status (q_status)
    );

    // Advance through the 16 slots of the head frame, drop it after the last
    sfsd_back u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_frame         (head_frame),
        .i_status        (q_status),
        .o_pop           (pop),
        .i_stall         (i_ch_stall),
        .o_valid         (o_ch_valid),
        .o_channel_index (o_channel_index),
        .o_raw_value     (o_raw_value),
        .o_pulse_us      (o_pulse_us),
        .o_last_channel  (o_last_channel)
    );

endmodule

// ----- sim/sbus_frame_sync_channel_decode_top_test.sv -----
`timescale 1ns / 1ps
// Self-checking testbench for the SBUS frame synchronizer and channel decoder top level.
module sbus_frame_sync_channel_decode_top_test;

    localparam int CYCLE_LIMIT  = 200000;
    localparam int HOLD_CYCLES  = 400;
    localparam int DRAIN_CYCLES = 40;
    localparam int RANDOM_BYTES = 20;
    localparam int PULSE_OFFSET = 7040;
    localparam int FRAME_BYTES  = sfsd_pkg::FRAME_LEN;

    // One decoded channel word as it leaves the block.
    typedef struct packed {
        logic [sfsd_pkg::SLOT_W-1:0]  idx;
        logic [sfsd_pkg::RAW_W-1:0]   raw;
        logic [sfsd_pkg::PULSE_W-1:0] pulse;
        logic                         last;
    } t_chan_word;

    logic                          i_clk      = 1'b0;
    logic                          i_rst_n    = 1'b0;
    logic                          i_rx_valid = 1'b0;
    logic [7:0]                    i_rx_byte  = 8'h00;
    logic                          i_ch_stall = 1'b0;
    logic                          o_rx_stall;
    logic                          o_ch_valid;
    logic [sfsd_pkg::SLOT_W-1:0]   o_channel_index;
    logic [sfsd_pkg::RAW_W-1:0]    o_raw_value;
    logic [sfsd_pkg::PULSE_W-1:0]  o_pulse_us;
    logic                          o_last_channel;

    // Shadow of the block: the 25-byte window and the unconsumed byte count.
    logic [7:0]  rx_window [FRAME_BYTES];
    int          rx_pending;
    t_chan_word  expected_channels [$];

    // Bit position of each channel slot inside the frame (byte * 8 + shift).
    int unsigned slot_bit_ofs [sfsd_pkg::NUM_SLOTS] = '{
        8, 52, 30, 19, 41, 63, 74, 85, 96, 107, 118, 129, 140, 151, 162, 173
    };

    logic [7:0]  frame_buf [FRAME_BYTES];
    int          mismatch_count = 0;
    int          cycle_count    = 0;
    int          bytes_sent     = 0;
    bit          pace_free      = 1'b0;
    bit          hold_go        = 1'b0;
    bit          hold_armed     = 1'b0;
    int          hold_left      = 0;

    sbus_frame_sync_channel_decode_top u_top (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_rx_valid      (i_rx_valid),
        .o_rx_stall      (o_rx_stall),
        .i_rx_byte       (i_rx_byte),
        .o_ch_valid      (o_ch_valid),
        .i_ch_stall      (i_ch_stall),
        .o_channel_index (o_channel_index),
        .o_raw_value     (o_raw_value),
        .o_pulse_us      (o_pulse_us),
        .o_last_channel  (o_last_channel)
    );

    always #5 i_clk = ~i_clk;

    // Abort a hung run.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end
    end

    function automatic bit is_footer(input logic [7:0] v);
        return v == sfsd_pkg::FOOTER_A || v == sfsd_pkg::FOOTER_B ||
               v == sfsd_pkg::FOOTER_C || v == sfsd_pkg::FOOTER_D;
    endfunction

    function automatic logic [7:0] random_footer();
        case ($urandom_range(0, 3))
            0: return sfsd_pkg::FOOTER_A;
            1: return sfsd_pkg::FOOTER_B;
            2: return sfsd_pkg::FOOTER_C;
            default: return sfsd_pkg::FOOTER_D;
        endcase
    endfunction

    // Any byte that does not close a frame; flip bit 0 off a valid footer.
    function automatic logic [7:0] broken_footer();
        logic [7:0] v;
        v = 8'($urandom_range(0, 255));
        if (is_footer(v))
            v = v ^ 8'h01;
        return v;
    endfunction

    // Shift one accepted byte into the shadow window; once 25 bytes are pending, queue
    // the 16 channel words if the oldest byte opens a frame that the newest one closes.
    function automatic void predict_rx_byte(input logic [7:0] b);
        logic [8*FRAME_BYTES-1:0] frame_bits;
        t_chan_word               w;
        int unsigned              raw;
        for (int i = 0; i < FRAME_BYTES - 1; i++)
            rx_window[i] = rx_window[i + 1];
        rx_window[FRAME_BYTES - 1] = b;
        if (rx_pending < FRAME_BYTES)
            rx_pending++;
        if (rx_pending < FRAME_BYTES)
            return;
        // No sync: drop the oldest byte only, the window keeps sliding.
        if (rx_window[0] != sfsd_pkg::SBUS_HEADER || !is_footer(rx_window[FRAME_BYTES - 1])) begin
            rx_pending = FRAME_BYTES - 1;
            return;
        end
        rx_pending = 0;
        for (int i = 0; i < FRAME_BYTES; i++)
            frame_bits[8*i +: 8] = rx_window[i];
        for (int k = 0; k < sfsd_pkg::NUM_SLOTS; k++) begin
            raw     = frame_bits[slot_bit_ofs[k] +: sfsd_pkg::RAW_W];
            w.idx   = sfsd_pkg::SLOT_W'(k);
            w.raw   = sfsd_pkg::RAW_W'(raw);
            // 0.625 * (raw - 1000) + 1505 in integer form
            w.pulse = sfsd_pkg::PULSE_W'((5 * raw + PULSE_OFFSET) >> 3);
            w.last  = (k == sfsd_pkg::NUM_SLOTS - 1);
            expected_channels.push_back(w);
        end
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("MISMATCH @%0d: %s got %0d want %0d", cycle_count, what, got, want);
        mismatch_count++;
    endtask

    // Offer one byte; idle first at random, then hold it until the block takes it.
    task automatic send_rx_byte(input logic [7:0] b);
        int gap;
        gap = 0;
        if (!pace_free)
            while ($urandom_range(0, 99) < 34)
                gap++;
        if (gap > 0) begin
            i_rx_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_rx_valid <= 1'b1;
        i_rx_byte  <= b;
        do @(posedge i_clk); while (o_rx_stall);
        predict_rx_byte(b);
        bytes_sent++;
    endtask

    // Fill frame_buf: header, 23 bytes of payload and flags, then the footer.
    // A negative fill draws every payload byte at random.
    task automatic build_frame(input int fill, input logic [7:0] footer);
        frame_buf[0] = sfsd_pkg::SBUS_HEADER;
        for (int i = 1; i < FRAME_BYTES - 1; i++)
            frame_buf[i] = (fill < 0) ? 8'($urandom_range(0, 255)) : 8'(fill);
        frame_buf[FRAME_BYTES - 1] = footer;
    endtask

    task automatic send_frame(input int len);
        for (int i = 0; i < len; i++)
            send_rx_byte(frame_buf[i]);
    endtask

    // Receiver: stall at random, or hold off for a long stretch once asked.
    always @(posedge i_clk) begin : drive_ch_stall
        logic stall_next;
        if (hold_go && !hold_armed) begin
            hold_armed <= 1'b1;
            hold_left  <= HOLD_CYCLES;
            stall_next = 1'b1;
        end else if (hold_left > 0) begin
            hold_left  <= hold_left - 1;
            stall_next = 1'b1;
        end else begin
            stall_next = !pace_free && ($urandom_range(0, 99) < 34);
        end
        if (!hold_go)
            hold_armed <= 1'b0;
        i_ch_stall <= stall_next;
    end

    // Compare every accepted channel word with the oldest expectation.
    always @(posedge i_clk) begin : check_channels
        t_chan_word want;
        if (i_rst_n && o_ch_valid && !i_ch_stall) begin
            if (expected_channels.size() == 0) begin
                report_mismatch("unexpected word, channel_index", o_channel_index, -1);
            end else begin
                want = expected_channels.pop_front();
                if (o_channel_index !== want.idx)
                    report_mismatch("channel_index", o_channel_index, want.idx);
                if (o_raw_value !== want.raw)
                    report_mismatch("raw_value", o_raw_value, want.raw);
                if (o_pulse_us !== want.pulse)
                    report_mismatch("pulse_us", o_pulse_us, want.pulse);
                if (o_last_channel !== want.last)
                    report_mismatch("last_channel", o_last_channel, want.last);
            end
        end
    end

    // The first 24 bytes only fill the window; the 25th completes a frame.
    task automatic test_partial_window();
        build_frame(-1, sfsd_pkg::FOOTER_B);
        send_frame(FRAME_BYTES);
    endtask

    // All-zero payload gives raw 0 on every slot, all-ones gives raw 2047.
    task automatic test_extreme_payloads();
        build_frame(8'h00, sfsd_pkg::FOOTER_A);
        send_frame(FRAME_BYTES);
        build_frame(8'hFF, sfsd_pkg::FOOTER_D);
        send_frame(FRAME_BYTES);
    endtask

    // Bad header, then bad footer: both slide through; then resync on a good frame.
    task automatic test_bad_sync();
        build_frame(-1, sfsd_pkg::FOOTER_C);
        frame_buf[0] = sfsd_pkg::SBUS_HEADER ^ 8'h01;
        send_frame(FRAME_BYTES);
        build_frame(-1, broken_footer());
        send_frame(FRAME_BYTES);
        build_frame(-1, sfsd_pkg::FOOTER_C);
        send_frame(FRAME_BYTES);
    endtask

    // Hold the receiver off while frames keep coming, so the frame queue fills
    // and the block has to stall its byte input.
    task automatic test_backpressure();
        hold_go <= 1'b1;
        repeat (3) begin
            build_frame(-1, random_footer());
            send_frame(FRAME_BYTES);
        end
        hold_go <= 1'b0;
    endtask

    // Back-to-back bytes and no receiver stalls.
    task automatic test_full_rate();
        pace_free <= 1'b1;
        repeat (2) begin
            build_frame(-1, random_footer());
            send_frame(FRAME_BYTES);
            send_rx_byte(8'($urandom_range(0, 255)));
        end
        pace_free <= 1'b0;
    endtask

    // Mostly well-formed frames with random content, mixed with broken frames,
    // truncated frames and stray bytes that often look like a header.
    task automatic test_random_stream();
        int start;
        int pick;
        start = bytes_sent;
        while (bytes_sent - start < RANDOM_BYTES) begin
            pick = $urandom_range(0, 99);
            build_frame(-1, random_footer());
            if (pick < 65) begin
                send_frame(FRAME_BYTES);
            end else if (pick < 72) begin
                frame_buf[0] = 8'($urandom_range(0, 255));
                if (frame_buf[0] == sfsd_pkg::SBUS_HEADER)
                    frame_buf[0] = frame_buf[0] ^ 8'h80;
                send_frame(FRAME_BYTES);
            end else if (pick < 79) begin
                frame_buf[FRAME_BYTES - 1] = broken_footer();
                send_frame(FRAME_BYTES);
            end else if (pick < 86) begin
                send_frame($urandom_range(1, FRAME_BYTES - 2));
            end else begin
                repeat ($urandom_range(1, 6))
                    send_rx_byte(($urandom_range(0, 3) == 0) ? sfsd_pkg::SBUS_HEADER
                                                              : 8'($urandom_range(0, 255)));
            end
        end
    endtask

    initial begin
        for (int i = 0; i < FRAME_BYTES; i++)
            rx_window[i] = 8'h00;
        rx_pending = 0;

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_partial_window();
        test_extreme_payloads();
        test_bad_sync();
        test_backpressure();
        test_full_rate();
        test_random_stream();

        // Drop valid, drain the outstanding words, then let the pipe settle.
        i_rx_valid <= 1'b0;
        while (expected_channels.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (mismatch_count == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
